>>> sv/rcl_pkg.sv
// ----------------------------------------------------------------------------
// Run control package
// Types, codes and a helper function shared by the run control and PWM drive.
// ----------------------------------------------------------------------------
`default_nettype none

package rcl_pkg;

    localparam int PWM_W = 16;
    localparam int SENS_W = 12;
    localparam int DIST_W = 32;
    localparam int SPD_W = 17;
    localparam int TIME_W = 32;
    localparam int CNT_W = 16;
    localparam int SEC_W = 23;
    localparam int MTK_W = 16;
    localparam int CMD_W = 2;
    localparam int PH_W = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam int NUM_SENSORS = 4;
    localparam int NUM_CMP = 4;

    // Division by 1000 of a 32-bit value: multiply by ceil(2^38 / 1000), keep the bits from bit 38 up.
    localparam int RECIP_W = 29;
    localparam logic [RECIP_W-1:0] SEC_RECIP = 29'd274877907;
    localparam int SEC_SHIFT = 38;
    localparam int PROD_W = TIME_W + RECIP_W;

    localparam logic [CMD_W-1:0] CMD_START = 2'd1;
    localparam logic [CMD_W-1:0] CMD_STOP = 2'd2;

    localparam logic [PH_W-1:0] PH_NONE = 2'd0;
    localparam logic [PH_W-1:0] PH_START = 2'd1;
    localparam logic [PH_W-1:0] PH_END = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PWM = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_THR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MARK_TICKS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MARK_EN = 2'd3;

    localparam logic [PWM_W-1:0] MAX_PWM_RST = 16'd1000;
    localparam logic [SENS_W-1:0] LINE_THR_RST = 12'd2000;
    localparam logic [MTK_W-1:0] MARK_TICKS_RST = 16'd10;

    typedef struct packed {
        logic [CMD_W-1:0]                    cmd;
        logic [NUM_SENSORS-1:0][SENS_W-1:0] sensors;
        logic [DIST_W-1:0]                   left_distance;
        logic [DIST_W-1:0]                   right_distance;
        logic [SPD_W-1:0]                    left_speed;
        logic [SPD_W-1:0]                    right_speed;
        logic [TIME_W-1:0]                   time_ms;
    } t_item;

    typedef struct packed {
        logic [NUM_CMP-1:0][PWM_W-1:0] cmp;
        logic                          running;
        logic                          all_seen;
        logic                          mark;
        logic                          done;
        logic [TIME_W-1:0]             diff;
        logic [PH_W-1:0]               phase;
    } t_res;

    // Returns {forward, reverse} compares for one wheel.
    function automatic logic [2*PWM_W-1:0] drive_wheel(input logic [SPD_W-1:0] spd,
                                                      input logic [PWM_W-1:0] maxp);
        logic             neg;
        logic [SPD_W-1:0] mag;
        logic [PWM_W-1:0] act;
        neg = spd[SPD_W-1];
        mag = neg ? SPD_W'(~spd + SPD_W'(1)) : spd;
        if (mag > SPD_W'(maxp)) begin
            act = '0;
        end else begin
            act = maxp - PWM_W'(mag);
        end
        return neg ? {maxp, act} : {act, maxp};
    endfunction

endpackage

`default_nettype wire

>>> sv/run_control_lap_mark_pwm_drive.sv
// ----------------------------------------------------------------------------
// Run control with lap-mark detection and PWM compare drive
// Takes one control tick per beat and returns one result beat per tick.
// ----------------------------------------------------------------------------
// A new tick can be accepted on every clock cycle while o_stall is low, and each
// tick yields exactly one result beat, carried through the input, second and
// third stages to the outputs. The run state is updated in the second stage;
// the third stage holds the product of the reciprocal multiply that turns the
// run time into seconds.
// Configuration registers are written through a separate port that is always
// ready, and should be written only while no tick is in flight.
`default_nettype none

module run_control_lap_mark_pwm_drive
    import rcl_pkg::*;
#(
    parameter int SENSOR_COUNT = 4
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_valid,
    output logic                   o_stall,
    input  wire  [CMD_W-1:0]       i_cmd,
    input  wire  [SENS_W-1:0]      i_sensor_a,
    input  wire  [SENS_W-1:0]      i_sensor_b,
    input  wire  [SENS_W-1:0]      i_sensor_c,
    input  wire  [SENS_W-1:0]      i_sensor_d,
    input  wire  [DIST_W-1:0]      i_left_distance,
    input  wire  [DIST_W-1:0]      i_right_distance,
    input  wire  signed [SPD_W-1:0] i_left_speed,
    input  wire  signed [SPD_W-1:0] i_right_speed,
    input  wire  [TIME_W-1:0]      i_time_ms,
    output logic                   o_valid,
    input  wire                    i_stall,
    output logic [PWM_W-1:0]       o_left_fwd_compare,
    output logic [PWM_W-1:0]       o_left_rev_compare,
    output logic [PWM_W-1:0]       o_right_fwd_compare,
    output logic [PWM_W-1:0]       o_right_rev_compare,
    output logic                   o_running,
    output logic                   o_line_all_seen,
    output logic                   o_mark_seen,
    output logic                   o_run_done,
    output logic [SEC_W-1:0]       o_run_seconds,
    output logic [PH_W-1:0]        o_mark_phase,
    input  wire                    i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire  [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire  [CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int NEED = (SENSOR_COUNT > NUM_SENSORS) ? NUM_SENSORS : SENSOR_COUNT;
    localparam logic [NUM_SENSORS-1:0] SENS_MASK = NUM_SENSORS'((1 << NEED) - 1);

    logic [PWM_W-1:0]  r_max_pwm;
    logic [SENS_W-1:0] r_thr;
    logic [MTK_W-1:0]  r_mark_ticks;
    logic              r_mark_en;

    logic              r_active, n_active;
    logic [PH_W-1:0]   r_phase, n_phase;
    logic              r_pending, n_pending;
    logic              r_timing, n_timing;
    logic [TIME_W-1:0] r_stamp, n_stamp;
    logic [DIST_W-1:0] r_last_l, n_last_l;
    logic [DIST_W-1:0] r_last_r, n_last_r;
    logic [CNT_W-1:0]  r_cnt_l, n_cnt_l;
    logic [CNT_W-1:0]  r_cnt_r, n_cnt_r;
    logic [NUM_CMP-1:0][PWM_W-1:0] r_cmp, n_cmp;
    logic [SEC_W-1:0]  r_last_sec;

    logic              r_v1, r_v2, r_v3;
    t_item             r_item;
    t_res              r_res2, r_res3, n_res;
    logic [PROD_W-1:0] r_prod;

    logic adv1, adv2, adv3;
    logic in_take, s2_take, s3_take, out_take;
    logic mark_stop, end_req, all_seen, mark;
    logic [NUM_SENSORS-1:0] hit;
    logic [2*PWM_W-1:0] drv_l, drv_r;

    assign adv3 = !r_v3 || !i_stall;
    assign adv2 = !r_v2 || adv3;
    assign adv1 = !r_v1 || adv2;
    assign o_stall = !adv1;
    assign in_take = i_valid && adv1;
    assign s2_take = r_v1 && adv2;
    assign s3_take = r_v2 && adv3;
    assign out_take = r_v3 && !i_stall;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_pwm <= MAX_PWM_RST;
            r_thr <= LINE_THR_RST;
            r_mark_ticks <= MARK_TICKS_RST;
            r_mark_en <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MAX_PWM: r_max_pwm <= i_cfg_data[PWM_W-1:0];
                CFG_LINE_THR: r_thr <= i_cfg_data[SENS_W-1:0];
                CFG_MARK_TICKS: r_mark_ticks <= i_cfg_data[MTK_W-1:0];
                CFG_MARK_EN: r_mark_en <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        for (int i = 0; i < NUM_SENSORS; i++) begin
            hit[i] = r_item.sensors[i] > r_thr;
        end
        drv_l = drive_wheel(r_item.left_speed, r_max_pwm);
        drv_r = drive_wheel(r_item.right_speed, r_max_pwm);
    end

    always_comb begin
        n_active = r_active;
        n_phase = r_phase;
        n_pending = r_pending;
        n_timing = r_timing;
        n_stamp = r_stamp;
        n_last_l = r_last_l;
        n_last_r = r_last_r;
        n_cnt_l = r_cnt_l;
        n_cnt_r = r_cnt_r;
        n_cmp = r_cmp;
        mark_stop = 1'b0;
        end_req = 1'b0;
        all_seen = 1'b0;
        mark = 1'b0;
        n_res.done = 1'b0;

        if (r_mark_en && r_pending) begin
            if (r_phase == PH_NONE) begin
                n_phase = PH_START;
                n_pending = 1'b0;
            end else if (r_phase == PH_START) begin
                n_phase = PH_END;
                n_pending = 1'b0;
                mark_stop = 1'b1;
                end_req = 1'b1;
            end
        end

        if (!mark_stop) begin
            if (r_item.cmd == CMD_STOP) begin
                end_req = 1'b1;
            end else if (r_item.cmd == CMD_START) begin
                n_phase = PH_NONE;
                n_timing = 1'b1;
                n_stamp = r_item.time_ms;
                n_active = 1'b1;
            end
        end

        if (end_req) begin
            for (int k = 0; k < NUM_CMP; k++) begin
                n_cmp[k] = r_max_pwm;
            end
            n_active = 1'b0;
            n_res.done = r_timing;
            n_timing = 1'b0;
        end

        if (n_active) begin
            n_cmp[0] = drv_l[2*PWM_W-1:PWM_W];
            n_cmp[1] = drv_l[PWM_W-1:0];
            n_cmp[2] = drv_r[2*PWM_W-1:PWM_W];
            n_cmp[3] = drv_r[PWM_W-1:0];
            all_seen = &(hit | ~SENS_MASK);
            if (!all_seen) begin
                n_cnt_l = '0;
                n_cnt_r = '0;
            end else begin
                if (r_item.left_distance != r_last_l) begin
                    n_last_l = r_item.left_distance;
                    if (r_cnt_l != '1) begin
                        n_cnt_l = r_cnt_l + 1'b1;
                    end
                end
                if (r_item.right_distance != r_last_r) begin
                    n_last_r = r_item.right_distance;
                    if (r_cnt_r != '1) begin
                        n_cnt_r = r_cnt_r + 1'b1;
                    end
                end
                if (n_cnt_l >= r_mark_ticks && n_cnt_r >= r_mark_ticks) begin
                    n_cnt_l = '0;
                    n_cnt_r = '0;
                    n_pending = 1'b1;
                    mark = 1'b1;
                end
            end
        end

        n_res.cmp = n_cmp;
        n_res.running = n_active;
        n_res.all_seen = all_seen;
        n_res.mark = mark;
        n_res.diff = r_item.time_ms - r_stamp;
        n_res.phase = n_phase;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_active <= 1'b0;
            r_phase <= PH_NONE;
            r_pending <= 1'b0;
            r_timing <= 1'b0;
            r_stamp <= '0;
            r_last_l <= '0;
            r_last_r <= '0;
            r_cnt_l <= '0;
            r_cnt_r <= '0;
            r_cmp <= '0;
            r_last_sec <= '0;
        end else begin
            if (adv1) begin
                r_v1 <= i_valid;
            end
            if (adv2) begin
                r_v2 <= r_v1;
            end
            if (adv3) begin
                r_v3 <= r_v2;
            end
            if (s2_take) begin
                r_active <= n_active;
                r_phase <= n_phase;
                r_pending <= n_pending;
                r_timing <= n_timing;
                r_stamp <= n_stamp;
                r_last_l <= n_last_l;
                r_last_r <= n_last_r;
                r_cnt_l <= n_cnt_l;
                r_cnt_r <= n_cnt_r;
                r_cmp <= n_cmp;
            end
            if (out_take) begin
                r_last_sec <= o_run_seconds;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_item.cmd <= i_cmd;
            r_item.sensors <= {i_sensor_d, i_sensor_c, i_sensor_b, i_sensor_a};
            r_item.left_distance <= i_left_distance;
            r_item.right_distance <= i_right_distance;
            r_item.left_speed <= i_left_speed;
            r_item.right_speed <= i_right_speed;
            r_item.time_ms <= i_time_ms;
        end
        if (s2_take) begin
            r_res2 <= n_res;
        end
        if (s3_take) begin
            r_res3 <= r_res2;
            r_prod <= PROD_W'(r_res2.diff) * PROD_W'(SEC_RECIP);
        end
    end

    assign o_valid = r_v3;
    assign o_left_fwd_compare = r_res3.cmp[0];
    assign o_left_rev_compare = r_res3.cmp[1];
    assign o_right_fwd_compare = r_res3.cmp[2];
    assign o_right_rev_compare = r_res3.cmp[3];
    assign o_running = r_res3.running;
    assign o_line_all_seen = r_res3.all_seen;
    assign o_mark_seen = r_res3.mark;
    assign o_run_done = r_res3.done;
    assign o_run_seconds = r_res3.done ? r_prod[SEC_SHIFT +: SEC_W] : r_last_sec;
    assign o_mark_phase = r_res3.phase;

endmodule

`default_nettype wire
